// ----- rtl/core/mfu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mfu_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS = 16;
	localparam int COUNT_BITS = 16;
	localparam int STAMP_BITS = 32;
	localparam int TOTAL_BITS = 32;
	localparam int CFG_BITS = 5;
	localparam int CFG_RESET = 16;
	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_FRAMES - 1);

	typedef enum logic {
		OP_PRELOAD = 1'b0,
		OP_REFERENCE = 1'b1
	} op_t;

	typedef struct packed {
		logic opcode;
		logic [PAGE_BITS-1:0] page_number;
		logic is_write;
	} item_t;

	typedef struct packed {
		logic hit;
		logic fault;
		logic evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic evicted_dirty;
		logic [TOTAL_BITS-1:0] fault_total;
	} result_t;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		logic dirty;
		logic [COUNT_BITS-1:0] count;
		logic [STAMP_BITS-1:0] arrival;
	} entry_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		entry_t entry;
	} frame_wr_t;

	typedef struct packed {
		logic hit;
		logic [IDX_W-1:0] hit_idx;
		entry_t hit_entry;
		logic free_found;
		logic [IDX_W-1:0] free_idx;
		logic [CNT_W-1:0] used;
		logic victim_found;
		logic [IDX_W-1:0] victim_idx;
		entry_t victim_entry;
	} scan_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} st_t;

endpackage
`default_nettype wire

// ----- rtl/core/mfu_page_replacement_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Most-frequently-used page replacement over a table of page frames.
// An item on the item port is taken at a rising edge where start is high
// and busy is low. A preload of a nonzero page not yet held fills the lowest
// free frame; a reference hits, or faults and fills a free frame or replaces
// the frame with the highest use count, the oldest arrival breaking ties.
// Every transaction yields one result on the result port, marked by done
// for exactly one cycle. The receiver cannot stall, so results are never
// held back or dropped.
// The item is first scanned: one shared compare unit reads one frame per cycle
// over all 16 frames. Then the update state decides and writes the table, and
// the result and done are registered from it. The next item may start while
// the result strobe is shown, since busy is low again.
// The frames_in_use register is written through the cfg channel while the
// block is idle; cfg_ready is low while busy.
// Reset empties every frame, sets frames_in_use to 16 and clears the
// arrival clock and the fault total. No clearing pass is needed.
module mfu_page_replacement_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire mfu_pkg::item_t item,
	output logic done,
	output mfu_pkg::result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [mfu_pkg::CFG_BITS-1:0] cfg_data
);
	import mfu_pkg::*;

	st_t state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	item_t item_q;
	logic [CFG_BITS-1:0] cfg_q;
	logic [STAMP_BITS-1:0] clock_q;
	logic [TOTAL_BITS-1:0] faults_q;
	logic done_q;
	result_t result_q;

	logic rd_valid;
	entry_t rd_entry;
	scan_res_t scan;
	frame_wr_t wr;
	logic scan_clear, scan_step, finish;
	logic [CNT_W-1:0] limit;
	logic has_free;
	logic [TOTAL_BITS-1:0] faults_next;
	logic [STAMP_BITS-1:0] clock_next;
	result_t res_d;

	mfu_frame_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_idx(idx_q),
		.rd_valid(rd_valid),
		.rd_entry(rd_entry),
		.wr(wr)
	);

	mfu_scan_unit u_scan (
		.clk(clk),
		.clear(scan_clear),
		.step(scan_step),
		.idx(idx_q),
		.page(item_q.page_number),
		.rd_valid(rd_valid),
		.rd_entry(rd_entry),
		.res(scan)
	);

	always_comb begin
		if (cfg_q == '0) begin
			limit = CNT_W'(1);
		end else if (32'(cfg_q) > MAX_FRAMES) begin
			limit = CNT_W'(MAX_FRAMES);
		end else begin
			limit = CNT_W'(cfg_q);
		end
	end

	assign has_free = scan.free_found && (scan.used < limit);

	always_comb begin
		state_d = state_q;
		scan_clear = 1'b0;
		scan_step = 1'b0;
		finish = 1'b0;
		busy = 1'b1;
		wr = '0;
		faults_next = faults_q;
		clock_next = clock_q;
		res_d = '0;
		res_d.fault_total = faults_q;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				scan_clear = 1'b1;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_step = 1'b1;
				if (idx_q == IDX_LAST) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				finish = 1'b1;
				state_d = ST_IDLE;
				wr.entry.page = item_q.page_number;
				wr.entry.dirty = item_q.is_write;
				wr.entry.count = COUNT_BITS'(1);
				wr.entry.arrival = clock_q;
				if (item_q.opcode == OP_PRELOAD) begin
					if ((item_q.page_number != '0) && !scan.hit && has_free) begin
						wr.en = 1'b1;
						wr.idx = scan.free_idx;
					end
				end else if (scan.hit) begin
					res_d.hit = 1'b1;
					wr.en = 1'b1;
					wr.idx = scan.hit_idx;
					wr.entry = scan.hit_entry;
					wr.entry.dirty = scan.hit_entry.dirty | item_q.is_write;
					if (scan.hit_entry.count != '1) begin
						wr.entry.count = scan.hit_entry.count + COUNT_BITS'(1);
					end
				end else begin
					res_d.fault = 1'b1;
					if (faults_q != '1) begin
						faults_next = faults_q + TOTAL_BITS'(1);
					end
					res_d.fault_total = faults_next;
					if (has_free) begin
						wr.en = 1'b1;
						wr.idx = scan.free_idx;
					end else if (scan.victim_found) begin
						wr.en = 1'b1;
						wr.idx = scan.victim_idx;
						res_d.evicted_valid = 1'b1;
						res_d.evicted_page = scan.victim_entry.page;
						res_d.evicted_dirty = scan.victim_entry.dirty;
					end
				end
				if (wr.en && !scan.hit && (clock_q != '1)) begin
					clock_next = clock_q + STAMP_BITS'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			cfg_q <= CFG_BITS'(CFG_RESET);
			clock_q <= '0;
			faults_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= finish;
			clock_q <= clock_next;
			faults_q <= faults_next;
			if (scan_step) begin
				idx_q <= idx_q + IDX_W'(1);
			end else begin
				idx_q <= '0;
			end
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
		if (finish) begin
			result_q <= res_d;
		end
	end

	assign cfg_ready = !busy;
	assign done = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ----- rtl/core/mfu_frame_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfu_frame_store (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [mfu_pkg::IDX_W-1:0] rd_idx,
	output logic rd_valid,
	output mfu_pkg::entry_t rd_entry,
	input wire mfu_pkg::frame_wr_t wr
);
	import mfu_pkg::*;

	logic [MAX_FRAMES-1:0] valid_q;
	entry_t entry_q [MAX_FRAMES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			entry_q[wr.idx] <= wr.entry;
		end
	end

	assign rd_valid = valid_q[rd_idx];
	assign rd_entry = entry_q[rd_idx];

endmodule
`default_nettype wire

// ----- rtl/core/mfu_scan_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfu_scan_unit (
	input wire logic clk,
	input wire logic clear,
	input wire logic step,
	input wire logic [mfu_pkg::IDX_W-1:0] idx,
	input wire logic [mfu_pkg::PAGE_BITS-1:0] page,
	input wire logic rd_valid,
	input wire mfu_pkg::entry_t rd_entry,
	output mfu_pkg::scan_res_t res
);
	import mfu_pkg::*;

	scan_res_t acc_q;
	logic better;

	always_comb begin
		better = !acc_q.victim_found
			|| (rd_entry.count > acc_q.victim_entry.count)
			|| ((rd_entry.count == acc_q.victim_entry.count)
				&& (rd_entry.arrival < acc_q.victim_entry.arrival));
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			acc_q.hit <= 1'b0;
			acc_q.free_found <= 1'b0;
			acc_q.victim_found <= 1'b0;
			acc_q.used <= '0;
		end else if (step) begin
			if (rd_valid) begin
				acc_q.used <= acc_q.used + CNT_W'(1);
				if (!acc_q.hit && (rd_entry.page == page)) begin
					acc_q.hit <= 1'b1;
					acc_q.hit_idx <= idx;
					acc_q.hit_entry <= rd_entry;
				end
				if (better) begin
					acc_q.victim_found <= 1'b1;
					acc_q.victim_idx <= idx;
					acc_q.victim_entry <= rd_entry;
				end
			end else if (!acc_q.free_found) begin
				acc_q.free_found <= 1'b1;
				acc_q.free_idx <= idx;
			end
		end
	end

	assign res = acc_q;

endmodule
`default_nettype wire

// ----- tb/mfu_page_replacement_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfu_page_replacement_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire mfu_pkg::item_t item,
	input wire logic done,
	input wire mfu_pkg::result_t result,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [mfu_pkg::CFG_BITS-1:0] cfg_data,
	output int fail_count,
	output int pending_results,
	output int results_checked,
	output int hit_count,
	output int fault_count,
	output int eviction_count,
	output int dirty_eviction_count,
	output int limit_writes
);
	import mfu_pkg::*;

	logic frame_live [MAX_FRAMES];
	entry_t frame_entry [MAX_FRAMES];
	logic [STAMP_BITS-1:0] arrival_clock;
	logic [TOTAL_BITS-1:0] fault_tally;
	logic [CFG_BITS-1:0] frames_in_use;
	result_t expected_results [$];
	result_t wanted_result;
	result_t predicted_result;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH after %0d results: %s", $realtime, results_checked, msg);
		fail_count++;
	endtask

	task automatic load_page(input int slot, input item_t it);
		frame_live[slot] = 1'b1;
		frame_entry[slot].page = it.page_number;
		frame_entry[slot].dirty = it.is_write;
		frame_entry[slot].count = COUNT_BITS'(1);
		frame_entry[slot].arrival = arrival_clock;
		if (arrival_clock != '1) begin
			arrival_clock++;
		end
	endtask

	task automatic predict_access(input item_t it, output result_t res);
		int limit;
		int used;
		int first_free;
		int slot;
		int victim;
		res = '0;
		limit = (frames_in_use == 0) ? 1 :
			((int'(frames_in_use) > MAX_FRAMES) ? MAX_FRAMES : int'(frames_in_use));
		used = 0;
		first_free = -1;
		slot = -1;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			if (frame_live[i]) begin
				used++;
				if (slot < 0 && frame_entry[i].page == it.page_number) begin
					slot = i;
				end
			end else if (first_free < 0) begin
				first_free = i;
			end
		end
		if (used >= limit) begin
			first_free = -1;
		end
		if (it.opcode == OP_PRELOAD) begin
			if (it.page_number != '0 && slot < 0 && first_free >= 0) begin
				load_page(first_free, it);
			end
		end else if (slot >= 0) begin
			res.hit = 1'b1;
			if (frame_entry[slot].count != '1) begin
				frame_entry[slot].count++;
			end
			if (it.is_write) begin
				frame_entry[slot].dirty = 1'b1;
			end
		end else begin
			res.fault = 1'b1;
			if (fault_tally != '1) begin
				fault_tally++;
			end
			slot = first_free;
			if (slot < 0) begin
				victim = -1;
				for (int i = 0; i < MAX_FRAMES; i++) begin
					if (frame_live[i]) begin
						if (victim < 0 ||
							frame_entry[i].count > frame_entry[victim].count ||
							(frame_entry[i].count == frame_entry[victim].count &&
							frame_entry[i].arrival < frame_entry[victim].arrival)) begin
							victim = i;
						end
					end
				end
				if (victim >= 0) begin
					res.evicted_valid = 1'b1;
					res.evicted_page = frame_entry[victim].page;
					res.evicted_dirty = frame_entry[victim].dirty;
					slot = victim;
				end
			end
			if (slot >= 0) begin
				load_page(slot, it);
			end
		end
		res.fault_total = fault_tally;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				frame_live[i] = 1'b0;
				frame_entry[i] = '0;
			end
			arrival_clock = '0;
			fault_tally = '0;
			frames_in_use = CFG_BITS'(CFG_RESET);
			expected_results.delete();
			fail_count = 0;
			pending_results = 0;
			results_checked = 0;
			hit_count = 0;
			fault_count = 0;
			eviction_count = 0;
			dirty_eviction_count = 0;
			limit_writes = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result 0x%h with no transaction pending",
						result));
				end else begin
					wanted_result = expected_results.pop_front();
					if (result.hit !== wanted_result.hit)
						report_mismatch($sformatf("hit got %b want %b",
							result.hit, wanted_result.hit));
					if (result.fault !== wanted_result.fault)
						report_mismatch($sformatf("fault got %b want %b",
							result.fault, wanted_result.fault));
					if (result.evicted_valid !== wanted_result.evicted_valid)
						report_mismatch($sformatf("evicted_valid got %b want %b",
							result.evicted_valid, wanted_result.evicted_valid));
					if (result.evicted_page !== wanted_result.evicted_page)
						report_mismatch($sformatf("evicted_page got 0x%h want 0x%h",
							result.evicted_page, wanted_result.evicted_page));
					if (result.evicted_dirty !== wanted_result.evicted_dirty)
						report_mismatch($sformatf("evicted_dirty got %b want %b",
							result.evicted_dirty, wanted_result.evicted_dirty));
					if (result.fault_total !== wanted_result.fault_total)
						report_mismatch($sformatf("fault_total got %0d want %0d",
							result.fault_total, wanted_result.fault_total));
					results_checked++;
					if (wanted_result.hit) hit_count++;
					if (wanted_result.fault) fault_count++;
					if (wanted_result.evicted_valid) eviction_count++;
					if (wanted_result.evicted_dirty) dirty_eviction_count++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				frames_in_use = cfg_data;
				limit_writes++;
			end
			if (start && !busy) begin
				predict_access(item, predicted_result);
				expected_results.insert(expected_results.size(), predicted_result);
			end
			pending_results = expected_results.size();
		end
	end

endmodule
`default_nettype wire

// ----- tb/mfu_page_replacement_top_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfu_page_replacement_top_test;
	import mfu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 65;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic done;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_BITS-1:0] cfg_data = '0;

	int fail_count;
	int pending_results;
	int results_checked;
	int hit_count;
	int fault_count;
	int eviction_count;
	int dirty_eviction_count;
	int limit_writes;
	int cycle_count = 0;
	bit sender_idles = 1'b1;
	logic [PAGE_BITS-1:0] working_set [$];

	mfu_page_replacement_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	mfu_page_replacement_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_results(pending_results),
		.results_checked(results_checked),
		.hit_count(hit_count),
		.fault_count(fault_count),
		.eviction_count(eviction_count),
		.dirty_eviction_count(dirty_eviction_count),
		.limit_writes(limit_writes)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("mfu_page_replacement_top test failed");
			$finish;
		end
	end

	task automatic issue_page_op(input op_t op, input logic [PAGE_BITS-1:0] page,
		input logic wr);
		@(negedge clk);
		if (sender_idles && $urandom_range(0, 2) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		item = '{opcode: op, page_number: page, is_write: wr};
		start = 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_results != 0 || busy) @(negedge clk);
	endtask

	task automatic set_frame_limit(input logic [CFG_BITS-1:0] value);
		drain_results();
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		logic [CFG_BITS-1:0] limit;
		logic [PAGE_BITS-1:0] page;
		int usable;
		int pick;
		int r;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, starting from the reset limit of sixteen frames.
		issue_page_op(OP_PRELOAD, 16'h0000, 1'b1);
		issue_page_op(OP_PRELOAD, 16'hFFFF, 1'b1);
		issue_page_op(OP_PRELOAD, 16'h0001, 1'b0);
		issue_page_op(OP_PRELOAD, 16'hFFFF, 1'b0);
		issue_page_op(OP_REFERENCE, 16'hFFFF, 1'b0);
		issue_page_op(OP_REFERENCE, 16'h0001, 1'b1);
		issue_page_op(OP_REFERENCE, 16'h0000, 1'b0);
		issue_page_op(OP_REFERENCE, 16'h8000, 1'b1);
		set_frame_limit(5'd0);
		issue_page_op(OP_PRELOAD, 16'h1234, 1'b0);
		issue_page_op(OP_REFERENCE, 16'h0001, 1'b0);
		issue_page_op(OP_REFERENCE, 16'h7FFF, 1'b0);
		issue_page_op(OP_REFERENCE, 16'h7FFF, 1'b0);
		issue_page_op(OP_REFERENCE, 16'h2222, 1'b0);
		issue_page_op(OP_REFERENCE, 16'h0000, 1'b1);
		set_frame_limit(5'd31);
		issue_page_op(OP_PRELOAD, 16'h1234, 1'b1);
		issue_page_op(OP_REFERENCE, 16'h4321, 1'b0);
		issue_page_op(OP_REFERENCE, 16'h1234, 1'b0);
		set_frame_limit(5'd1);
		issue_page_op(OP_REFERENCE, 16'h5555, 1'b1);
		issue_page_op(OP_REFERENCE, 16'hAAAA, 1'b0);
		issue_page_op(OP_PRELOAD, 16'h6666, 1'b1);

		// Random phases over a range of frame limits, each with its own working set.
		for (int phase = 0; phase < PHASES; phase++) begin
			unique case (phase)
				0: limit = 5'd31;
				1: limit = 5'd1;
				2: limit = 5'd4;
				3: limit = 5'd0;
				4: limit = 5'd17;
				6: limit = 5'd8;
				7: limit = 5'd16;
				8: limit = 5'd2;
				default: limit = CFG_BITS'($urandom_range(0, 31));
			endcase
			set_frame_limit(limit);
			sender_idles = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
			usable = (limit == 0) ? 1 : ((int'(limit) > MAX_FRAMES) ? MAX_FRAMES : int'(limit));
			working_set.delete();
			repeat ($urandom_range(1, usable + 5)) begin
				if ($urandom_range(0, 9) == 0)
					working_set.insert(working_set.size(),
						PAGE_BITS'($urandom_range(0, 7)));
				else
					working_set.insert(working_set.size(),
						PAGE_BITS'($urandom_range(0, 65535)));
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, working_set.size() - 1);
				pick = $urandom_range(0, pick);
				page = working_set[pick];
				r = $urandom_range(0, 99);
				if (r < 60)
					issue_page_op(OP_REFERENCE, page, 1'($urandom_range(0, 1)));
				else if (r < 75)
					issue_page_op(OP_PRELOAD, page, 1'($urandom_range(0, 1)));
				else if (r < 85)
					issue_page_op(OP_REFERENCE, PAGE_BITS'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)));
				else if (r < 92)
					issue_page_op(OP_PRELOAD, PAGE_BITS'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)));
				else
					issue_page_op(op_t'($urandom_range(0, 1)), '0, 1'($urandom_range(0, 1)));
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		$display("Checked %0d results: %0d hits, %0d faults, %0d evictions (%0d dirty).",
			results_checked, hit_count, fault_count, eviction_count, dirty_eviction_count);
		$display("Frame limit was written %0d times, including 0, 1, 16 and out-of-range values.",
			limit_writes);
		if (fail_count == 0) begin
			$display("mfu_page_replacement_top test passed");
		end else begin
			$display("mfu_page_replacement_top test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- mfu_page_replacement_top.f -----
rtl/core/mfu_pkg.sv
rtl/core/mfu_frame_store.sv
rtl/core/mfu_scan_unit.sv
rtl/core/mfu_page_replacement_top.sv
tb/mfu_page_replacement_checker.sv
tb/mfu_page_replacement_top_test.sv
